/* hdl/md5_pkg.sv */
// md5_pkg: shared types, constants and round functions of the md5 digest stream
// depends on nothing; imported by every module of the block
package md5_pkg;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // initial chaining values
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [31:0] PAD_WORD  = 32'h00000080;
  localparam logic [3:0]  LEN_SLOT  = 4'd14;
  localparam logic [3:0]  LAST_SLOT = 4'd15;
  localparam logic [2:0]  FULL_BYTES = 3'd4;
  localparam logic [5:0]  LAST_ROUND = 6'd63;

  // one queue entry: a word for the block buffer or a digest request
  typedef struct packed {
    logic        emit;
    logic [31:0] word;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_X80,
    F_PAD,
    F_LEN_HI,
    F_TERM
  } f_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LOAD,
    B_ROUND,
    B_ADD,
    B_OUT
  } b_state_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // message word used by a round
  function automatic logic [3:0] md5_msg_idx(input logic [5:0] r);
    logic [7:0] rx;
    logic [7:0] t;
    rx = {2'b00, r};
    case (r[5:4])
      2'd0:    t = rx;
      2'd1:    t = 8'd5 * rx + 8'd1;
      2'd2:    t = 8'd3 * rx + 8'd5;
      default: t = 8'd7 * rx;
    endcase
    return t[3:0];
  endfunction

  function automatic logic [4:0] md5_rot_amt(input logic [5:0] r);
    return ROT_AMT[{r[5:4], r[1:0]}];
  endfunction

  // nonlinear function of the round group
  function automatic logic [31:0] md5_f(input logic [1:0] grp, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (grp)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (d & b) | (~d & c);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] md5_rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage

/* hdl/md5_cmd_queue.sv */
// md5_cmd_queue: short register queue of commands between front and back
// depends on md5_pkg
module md5_cmd_queue
  import md5_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    enq,
  input  cmd_t    enq_cmd,
  input  logic    deq,
  output cmd_t    head,
  output q_stat_t stat
);

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_enq, do_deq;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_enq     = enq && !stat.full;
  assign do_deq     = deq && !stat.empty;
  assign head       = slot_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_enq) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_deq) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_enq && !do_deq) cnt_r <= cnt_r + 1'b1;
      else if (do_deq && !do_enq) cnt_r <= cnt_r - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_enq) slot_r[wr_ptr_r] <= enq_cmd;
  end

endmodule

/* hdl/md5_front.sv */
// md5_front: accepts message words, tracks length, expands padding into commands
// depends on md5_pkg
module md5_front
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [31:0] message_word,
  input  logic [2:0]  valid_bytes,
  input  logic        final_word,
  input  q_stat_t     q_stat,
  output logic        enq,
  output cmd_t        enq_cmd
);

  f_state_t    state_r, state_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic [63:0] len_r, len_nxt;
  logic [2:0]  nbytes;
  logic [31:0] tail_word;
  logic        take;

  assign full = (state_r != F_IDLE) || q_stat.full;
  assign take = push && !full;

  // saturate the byte count and build the last data word, with its pad byte when it is short
  always_comb begin
    nbytes = (valid_bytes > FULL_BYTES) ? FULL_BYTES : valid_bytes;
    case (nbytes)
      3'd0:    tail_word = PAD_WORD;
      3'd1:    tail_word = {16'h0000, PAD_WORD[7:0], message_word[7:0]};
      3'd2:    tail_word = {8'h00, PAD_WORD[7:0], message_word[15:0]};
      3'd3:    tail_word = {PAD_WORD[7:0], message_word[23:0]};
      default: tail_word = message_word;
    endcase
  end

  // next state and command generation
  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    len_nxt      = len_r;
    enq          = 1'b0;
    enq_cmd.emit = 1'b0;
    enq_cmd.word = message_word;
    unique case (state_r)
      F_IDLE: begin
        if (take) begin
          enq      = 1'b1;
          fill_nxt = fill_r + 1'b1;
          if (!final_word) begin
            len_nxt = len_r + 64'd32;
          end else begin
            len_nxt      = len_r + {58'd0, nbytes, 3'b000};
            enq_cmd.word = tail_word;
            state_nxt    = (nbytes == FULL_BYTES) ? F_X80 : F_PAD;
          end
        end
      end
      F_X80: begin
        enq_cmd.word = PAD_WORD;
        if (!q_stat.full) begin
          enq       = 1'b1;
          fill_nxt  = fill_r + 1'b1;
          state_nxt = F_PAD;
        end
      end
      F_PAD: begin
        enq_cmd.word = (fill_r == LEN_SLOT) ? len_r[31:0] : 32'h0;
        if (!q_stat.full) begin
          enq      = 1'b1;
          fill_nxt = fill_r + 1'b1;
          if (fill_r == LEN_SLOT) state_nxt = F_LEN_HI;
        end
      end
      F_LEN_HI: begin
        enq_cmd.word = len_r[63:32];
        if (!q_stat.full) begin
          enq       = 1'b1;
          fill_nxt  = fill_r + 1'b1;
          state_nxt = F_TERM;
        end
      end
      F_TERM: begin
        enq_cmd.emit = 1'b1;
        if (!q_stat.full) begin
          enq       = 1'b1;
          fill_nxt  = '0;
          len_nxt   = '0;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // state, slot position and bit length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      fill_r  <= '0;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

/* hdl/md5_core.sv */
// md5_core: block buffer, one-round-per-cycle compression and digest output
// depends on md5_pkg
module md5_core
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        head,
  input  q_stat_t     q_stat,
  output logic        deq,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_of_digest
);

  b_state_t    state_r, state_nxt;
  logic [31:0] buf_r [16];
  logic [31:0] chain_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] km_r;
  logic [5:0]  rnd_r, rnd_next;
  logic [3:0]  fill_r;
  logic [1:0]  idx_r;
  logic [31:0] sum, rot;
  logic        take_word, beat;

  assign empty          = (state_r != B_OUT);
  assign beat           = pop && !empty;
  assign digest_word    = chain_r[idx_r];
  assign word_index     = idx_r;
  assign last_of_digest = (idx_r == 2'd3);
  assign rnd_next       = rnd_r + 1'b1;

  // one round of the compression
  assign sum = md5_f(rnd_r[5:4], b_r, c_r, d_r) + a_r + km_r;
  assign rot = md5_rotl(sum, md5_rot_amt(rnd_r));

  // next state and queue pop
  always_comb begin
    state_nxt = state_r;
    deq       = 1'b0;
    take_word = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          deq = 1'b1;
          if (head.emit) begin
            state_nxt = B_OUT;
          end else begin
            take_word = 1'b1;
            if (fill_r == LAST_SLOT) state_nxt = B_LOAD;
          end
        end
      end
      B_LOAD:  state_nxt = B_ROUND;
      B_ROUND: if (rnd_r == LAST_ROUND) state_nxt = B_ADD;
      B_ADD:   state_nxt = B_IDLE;
      B_OUT:   if (beat && idx_r == 2'd3) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // control registers and chaining words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_IDLE;
      fill_r     <= '0;
      idx_r      <= '0;
      rnd_r      <= '0;
      chain_r[0] <= IV_A;
      chain_r[1] <= IV_B;
      chain_r[2] <= IV_C;
      chain_r[3] <= IV_D;
    end else begin
      state_r <= state_nxt;
      if (take_word) fill_r <= fill_r + 1'b1;
      if (state_r == B_LOAD) rnd_r <= '0;
      else if (state_r == B_ROUND) rnd_r <= rnd_next;
      if (state_r == B_ADD) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
      end
      if (beat) begin
        idx_r <= idx_r + 1'b1;
        if (idx_r == 2'd3) begin
          chain_r[0] <= IV_A;
          chain_r[1] <= IV_B;
          chain_r[2] <= IV_C;
          chain_r[3] <= IV_D;
        end
      end
    end
  end

  // block buffer
  always_ff @(posedge clk) begin
    if (take_word) buf_r[fill_r] <= head.word;
  end

  // working variables and prefetched constant plus message word
  always_ff @(posedge clk) begin
    if (state_r == B_LOAD) begin
      a_r  <= chain_r[0];
      b_r  <= chain_r[1];
      c_r  <= chain_r[2];
      d_r  <= chain_r[3];
      km_r <= ROUND_K[0] + buf_r[md5_msg_idx(6'd0)];
    end else if (state_r == B_ROUND) begin
      a_r  <= d_r;
      d_r  <= c_r;
      c_r  <= b_r;
      b_r  <= b_r + rot;
      km_r <= ROUND_K[rnd_next] + buf_r[md5_msg_idx(rnd_next)];
    end
  end

endmodule

/* hdl/md5_digest_stream.sv */
// md5_digest_stream: a message word is taken while the front is idle and the command queue
// has room. the back buffers 16 words, then loads, runs 64 rounds and adds into the chain,
// taking no new word meanwhile, so the single round unit sets the sustained rate.
// a final word adds the padding words, then four digest beats follow, one per cycle with pop.
// reset: synchronous active-low rst_n clears control and loads the initial chain.
module md5_digest_stream
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_final_word,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_last_of_digest
);

  q_stat_t q_stat;
  cmd_t    enq_cmd, head;
  logic    enq, deq;

  // front: accept beats, pad and count length
  md5_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .message_word (in_message_word),
    .valid_bytes  (in_valid_bytes),
    .final_word   (in_final_word),
    .q_stat       (q_stat),
    .enq          (enq),
    .enq_cmd      (enq_cmd)
  );

  // command queue
  md5_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .enq     (enq),
    .enq_cmd (enq_cmd),
    .deq     (deq),
    .head    (head),
    .stat    (q_stat)
  );

  // back: compression and digest beats
  md5_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_stat         (q_stat),
    .deq            (deq),
    .empty          (empty),
    .pop            (pop),
    .digest_word    (out_digest_word),
    .word_index     (out_word_index),
    .last_of_digest (out_last_of_digest)
  );

endmodule

/* tb/sv/md5_digest_stream_test.sv */
// md5_digest_stream_test: self-checking testbench for the md5 digest stream block
// keeps its own md5 predictor and compares every digest beat against it
// depends on md5_digest_stream and md5_pkg from hdl
module md5_digest_stream_test;
  timeunit 1ns;
  timeprecision 1ps;

  // one expected digest beat
  typedef struct {
    logic [31:0] digest;
    logic [1:0]  index;
    logic        last;
  } digest_beat_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [31:0] PAD_BYTE = 32'h00000080;
  localparam logic [3:0]  LEN_LO_POS = 4'd14;
  localparam logic [3:0]  BUF_END_POS = 4'd15;
  localparam logic [2:0]  WORD_BYTES = 3'd4;
  localparam int          IDLE_PCT = 28;
  localparam int          RANDOM_ITEMS = 260;

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int SHIFT_TAB [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                    4, 11, 16, 23, 6, 10, 15, 21};

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [31:0] in_message_word;
  logic [2:0]  in_valid_bytes;
  logic        in_final_word;
  logic        empty;
  logic        pop;
  logic [31:0] out_digest_word;
  logic [1:0]  out_word_index;
  logic        out_last_of_digest;

  // predictor state
  logic [31:0]  chain_st [4];
  logic [31:0]  blk_st [16];
  logic [3:0]   fill_st;
  logic [63:0]  bitlen_st;
  digest_beat_t digest_q [$];

  int err_count = 0;
  int items_sent = 0;
  int rx_hold = 0;
  bit steady = 1'b0;

  md5_digest_stream DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_message_word    (in_message_word),
    .in_valid_bytes     (in_valid_bytes),
    .in_final_word      (in_final_word),
    .empty              (empty),
    .pop                (pop),
    .out_digest_word    (out_digest_word),
    .out_word_index     (out_word_index),
    .out_last_of_digest (out_last_of_digest)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit, far above the slowest correct run
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic chain_load();
    chain_st[0] = INIT_A;
    chain_st[1] = INIT_B;
    chain_st[2] = INIT_C;
    chain_st[3] = INIT_D;
    fill_st = '0;
    bitlen_st = '0;
  endtask

  // 64 rounds over the block buffer, folded into the chain
  task automatic md5_compress();
    logic [31:0] a, b, c, d, f, sum, tmp;
    int g;
    a = chain_st[0];
    b = chain_st[1];
    c = chain_st[2];
    d = chain_st[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      sum = f + a + SINE_K[r] + blk_st[g];
      tmp = d;
      d = c;
      c = b;
      b = b + rotl32(sum, SHIFT_TAB[(r / 16) * 4 + r % 4]);
      a = tmp;
    end
    chain_st[0] += a;
    chain_st[1] += b;
    chain_st[2] += c;
    chain_st[3] += d;
  endtask

  task automatic buffer_word(input logic [31:0] w);
    blk_st[fill_st] = w;
    if (fill_st == BUF_END_POS) begin
      md5_compress();
      fill_st = '0;
    end else begin
      fill_st = fill_st + 4'd1;
    end
  endtask

  // one accepted word; a final word pads, closes the message and queues the digest
  task automatic md5_absorb(input logic [31:0] w, input logic [2:0] nb, input logic fin);
    logic [2:0]   nbytes;
    logic [31:0]  mask;
    digest_beat_t beat;
    if (!fin) begin
      bitlen_st += 64'd32;
      buffer_word(w);
      return;
    end
    nbytes = (nb > WORD_BYTES) ? WORD_BYTES : nb;
    bitlen_st += 64'(8 * nbytes);
    if (nbytes == WORD_BYTES) begin
      buffer_word(w);
      buffer_word(PAD_BYTE);
    end else begin
      mask = (nbytes == 3'd0) ? 32'h0 : (32'hffffffff >> (32 - 8 * nbytes));
      buffer_word((w & mask) | (PAD_BYTE << (8 * nbytes)));
    end
    while (fill_st != LEN_LO_POS) buffer_word(32'h0);
    buffer_word(bitlen_st[31:0]);
    buffer_word(bitlen_st[63:32]);
    for (int k = 0; k < 4; k++) begin
      beat.digest = chain_st[k];
      beat.index = 2'(k);
      beat.last = (k == 3);
      digest_q = {digest_q, beat};
    end
    chain_load();
  endtask

  // offer one word, with random gaps ahead of it outside steady mode, and hold it until taken
  task automatic send_word(input logic [31:0] w, input logic [2:0] nb, input logic fin);
    @(negedge clk);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        push <= 1'b0;
        @(negedge clk);
      end
    end
    push <= 1'b1;
    in_message_word <= w;
    in_valid_bytes <= nb;
    in_final_word <= fin;
    do @(posedge clk); while (full);
    md5_absorb(w, nb, fin);
    items_sent++;
  endtask

  task automatic sender_idle();
    @(negedge clk);
    push <= 1'b0;
  endtask

  // random message: full words of random content, then a random final word
  task automatic send_message(input int nwords);
    for (int i = 0; i < nwords; i++) send_word($urandom, 3'($urandom_range(7)), 1'b0);
    send_word($urandom, 3'($urandom_range(7)), 1'b1);
  endtask

  task automatic wait_drained();
    sender_idle();
    while (digest_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // result side: random pops (constant pops in steady mode), with a counted hold-off on request
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        pop <= 1'b0;
        rx_hold--;
      end else if (steady) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // compare every popped beat with the oldest expectation
  always @(posedge clk) begin
    digest_beat_t want;
    if (rst_n && pop && !empty) begin
      if (digest_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("%0t unexpected digest beat %h idx %0d last %0b", $realtime,
                   out_digest_word, out_word_index, out_last_of_digest);
      end else begin
        want = digest_q.pop_front();
        if (out_digest_word !== want.digest || out_word_index !== want.index ||
            out_last_of_digest !== want.last) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b", $realtime,
                     want.digest, want.index, want.last,
                     out_digest_word, out_word_index, out_last_of_digest);
        end
      end
    end
  end

  // empty message, a full final word, and short final words with junk above the valid bytes
  task automatic test_short_messages();
    send_word(32'hffffffff, 3'd0, 1'b1);
    send_word(32'hff636261, 3'd3, 1'b1);
    send_word(32'h00000000, 3'd4, 1'b1);
    send_word(32'haaaaaa55, 3'd1, 1'b1);
  endtask

  // valid count above four on a final word, short count on a non-final word
  task automatic test_valid_counts();
    send_word(32'hffffffff, 3'd5, 1'b1);
    send_word(32'h12345678, 3'd6, 1'b1);
    send_word(32'hffffffff, 3'd7, 1'b1);
    send_word(32'h00000000, 3'd0, 1'b0);
    send_word(32'hdeadbeef, 3'd2, 1'b1);
  endtask

  // final word lands where padding spills into a second block
  task automatic test_block_boundary();
    for (int i = 0; i < 14; i++)
      send_word((i % 2) ? 32'hffffffff : 32'h00000000, 3'(i % 8), 1'b0);
    send_word(32'h80000001, 3'd4, 1'b1);
  endtask

  // result side stalls a long time while words keep coming
  task automatic test_output_backpressure();
    rx_hold = 400;
    for (int m = 0; m < 10; m++) send_message($urandom_range(2));
    wait_drained();
  endtask

  // sender stops until every digest beat is back
  task automatic test_sender_pause();
    send_message(3);
    wait_drained();
    send_message(17);
  endtask

  // random messages, first without idling, then with idling on both sides
  task automatic test_random_messages();
    int start;
    start = items_sent;
    steady = 1'b1;
    while (items_sent - start < 80) send_message($urandom_range(18));
    steady = 1'b0;
    while (items_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(9) == 0) send_message($urandom_range(20, 40));
      else send_message($urandom_range(16));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_message_word = '0;
    in_valid_bytes = '0;
    in_final_word = 1'b0;
    chain_load();
    foreach (blk_st[i]) blk_st[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_short_messages();
    test_valid_counts();
    test_block_boundary();
    test_output_backpressure();
    test_sender_pause();
    test_random_messages();

    wait_drained();
    repeat (100) @(posedge clk);
    if (digest_q.size() != 0) err_count++;
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
